// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds while reset is held.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/core/uapw_pkg.sv
// Shared types, constants and helpers of the unacked packet window.
`default_nettype none

package uapw_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int PN_W         = 32;
    localparam int LEN_W        = 16;
    localparam int FLIGHT_W     = 22;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 80;
    localparam int OUT_USED_W   = PN_W + LEN_W + 1 + FLIGHT_W + 2;

    localparam logic [FLIGHT_W-1:0] FLIGHT_MAX = {FLIGHT_W{1'b1}};

    localparam logic KIND_LOST = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [1:0] {
        OP_SEND   = 2'd0,
        OP_ACK    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PRUNE  = 2'd3
    } uapw_op_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BACKWARD = 2'd1,
        ERR_FULL     = 2'd2,
        ERR_ORDER    = 2'd3
    } uapw_err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND_CHK,
        ST_FILL,
        ST_SEND_WR,
        ST_ACK_SET,
        ST_WALK,
        ST_LOST,
        ST_RM_CHK,
        ST_RM_SUB,
        ST_PRUNE,
        ST_DONE
    } uapw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic send_check;
        logic fill_step;
        logic send_write;
        logic ack_setup;
        logic walk_next;
        logic mem_read;
        logic emit_lost;
        logic remove_clear;
        logic prune_step;
        logic emit_done;
    } uapw_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        uapw_op_t new_op;
        logic     err_set;
        logic     fill_left;
        logic     walk_more;
        logic     slot_busy;
        logic     rm_hit;
        logic     prune_more;
        logic     out_free;
    } uapw_stat_t;

    // Ring position of the entry that lies off entries past the head.
    function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] base,
                                                    input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
            if (sum >= (CNT_W + 1)'(WINDOW_DEPTH))
            begin
                sum = sum - (CNT_W + 1)'(WINDOW_DEPTH);
            end
            return sum[SLOT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/uapw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module uapw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/uapw_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module uapw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire uapw_pkg::uapw_stat_t stat,
    output logic                     in_ready,
    output uapw_pkg::uapw_ctl_t      ctl
);
    import uapw_pkg::*;

    uapw_state_t state_reg;
    uapw_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    case (stat.new_op)
                        OP_SEND:   state_next = ST_SEND_CHK;
                        OP_ACK:    state_next = ST_ACK_SET;
                        OP_REMOVE: state_next = ST_RM_CHK;
                        OP_PRUNE:  state_next = ST_PRUNE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEND_CHK:
            begin
                ctl.send_check = 1'b1;
                state_next     = ST_FILL;
            end
            ST_FILL:
            begin
                if (stat.err_set)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.fill_left)
                begin
                    ctl.fill_step = 1'b1;
                end
                else
                begin
                    state_next = ST_SEND_WR;
                end
            end
            ST_SEND_WR:
            begin
                ctl.send_write = 1'b1;
                state_next     = ST_DONE;
            end
            ST_ACK_SET:
            begin
                ctl.ack_setup = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                if (!stat.walk_more)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.slot_busy)
                begin
                    ctl.mem_read = 1'b1;
                    state_next   = ST_LOST;
                end
                else
                begin
                    ctl.walk_next = 1'b1;
                end
            end
            ST_LOST:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_lost = 1'b1;
                    ctl.walk_next = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_RM_CHK:
            begin
                if (stat.rm_hit)
                begin
                    ctl.mem_read = 1'b1;
                    state_next   = ST_RM_SUB;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RM_SUB:
            begin
                ctl.remove_clear = 1'b1;
                state_next       = ST_DONE;
            end
            ST_PRUNE:
            begin
                if (stat.prune_more)
                begin
                    ctl.prune_step = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/uapw_dp.sv
// Datapath: window state, ring of in-flight bits, byte RAM and result register.
`default_nettype none

module uapw_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire uapw_pkg::uapw_ctl_t               ctl,
    output uapw_pkg::uapw_stat_t                   stat,
    input  wire logic [1:0]                        in_op,
    input  wire logic [uapw_pkg::IN_DATA_W-1:0]    in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [uapw_pkg::OUT_DATA_W-1:0]        out_data,
    output logic                                   out_kind,
    output logic                                   out_last
);
    import uapw_pkg::*;

    // Window state.
    logic [PN_W-1:0]         oldest_reg;
    logic                    nothing_sent_reg;
    logic [SLOT_W-1:0]       head_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [FLIGHT_W-1:0]     flight_reg;
    logic [WINDOW_DEPTH-1:0] inflight_reg;
    logic [PN_W-1:0]         prev_ack_reg;
    logic                    gap_reg;
    uapw_err_t               err_reg;

    // Walk and fill counters.
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] walk_off_reg;
    logic [CNT_W-1:0] walk_end_reg;

    // Captured request.
    uapw_op_t        op_reg;
    logic [PN_W-1:0] pn_reg;
    logic [LEN_W-1:0] len_reg;
    logic            fl_reg;
    logic            first_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_kind_reg;
    logic                  out_last_reg;

    logic [LEN_W-1:0] mem_rdata;

    // Send check.
    logic [PN_W-1:0] eff_old;
    logic [PN_W:0]   next_pn;
    logic [PN_W-1:0] send_dist;
    logic            send_back;
    logic            send_full;
    logic [SLOT_W-1:0] count_slot;
    logic [FLIGHT_W:0] flight_sum;

    // Ack gap bounds.
    logic [PN_W:0]    win_lo;
    logic [PN_W:0]    win_hi;
    logic [PN_W:0]    gap_lo;
    logic [PN_W:0]    gap_hi;
    logic             gap_some;
    logic             gap_out;
    logic             order_err;
    logic [CNT_W-1:0] lo_off;
    logic [CNT_W-1:0] hi_off;
    logic [SLOT_W-1:0] walk_slot;
    logic [PN_W-1:0]  lost_num;

    // Remove lookup.
    logic             rm_in_win;
    logic [SLOT_W-1:0] rm_slot;
    logic [FLIGHT_W-1:0] rm_bytes;
    logic [FLIGHT_W-1:0] rm_sub;

    logic [SLOT_W-1:0] ram_waddr;
    logic [LEN_W-1:0]  ram_wdata;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_raddr;

    // Send bounds against the window.
    always_comb
    begin
        eff_old    = nothing_sent_reg ? pn_reg : oldest_reg;
        next_pn    = (PN_W + 1)'(eff_old) + (PN_W + 1)'(count_reg);
        send_back  = (PN_W + 1)'(pn_reg) < next_pn;
        send_dist  = pn_reg - eff_old;
        send_full  = send_dist >= PN_W'(WINDOW_DEPTH);
        count_slot = ring_slot(head_reg, count_reg);
        flight_sum = (FLIGHT_W + 1)'(flight_reg) + (FLIGHT_W + 1)'(len_reg);
    end

    // Gap of an ack clipped to the window, as entry offsets.
    always_comb
    begin
        win_lo    = (PN_W + 1)'(oldest_reg);
        win_hi    = win_lo + (PN_W + 1)'(count_reg);
        gap_lo    = first_reg ? win_lo : (PN_W + 1)'(prev_ack_reg) + (PN_W + 1)'(1);
        gap_hi    = (PN_W + 1)'(pn_reg);
        gap_some  = gap_lo < gap_hi;
        gap_out   = gap_some && (nothing_sent_reg || gap_lo < win_lo || gap_hi > win_hi);
        order_err = !first_reg && (pn_reg <= prev_ack_reg);
        if (gap_lo <= win_lo)
        begin
            lo_off = '0;
        end
        else if (gap_lo >= win_hi)
        begin
            lo_off = count_reg;
        end
        else
        begin
            lo_off = CNT_W'(gap_lo - win_lo);
        end
        if (gap_hi <= win_lo)
        begin
            hi_off = '0;
        end
        else if (gap_hi >= win_hi)
        begin
            hi_off = count_reg;
        end
        else
        begin
            hi_off = CNT_W'(gap_hi - win_lo);
        end
        walk_slot = ring_slot(head_reg, walk_off_reg);
        lost_num  = oldest_reg + PN_W'(walk_off_reg);
    end

    // Remove lookup and clamped byte count.
    always_comb
    begin
        rm_in_win = !nothing_sent_reg && (pn_reg >= oldest_reg)
                    && ((PN_W + 1)'(pn_reg) < win_hi);
        rm_slot   = ring_slot(head_reg, CNT_W'(pn_reg - oldest_reg));
        rm_bytes  = FLIGHT_W'(mem_rdata);
        rm_sub    = (rm_bytes > flight_reg) ? flight_reg : rm_bytes;
    end

    // Byte RAM ports.
    always_comb
    begin
        ram_we    = ctl.fill_step || ctl.send_write;
        ram_waddr = count_slot;
        ram_wdata = ctl.send_write ? len_reg : '0;
        ram_raddr = (op_reg == OP_REMOVE) ? rm_slot : walk_slot;
    end

    uapw_ram #(
        .WIDTH(LEN_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_bytes (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ctl.mem_read),
        .raddr(ram_raddr),
        .rdata(mem_rdata)
    );

    // Window and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg       <= '0;
            nothing_sent_reg <= 1'b1;
            head_reg         <= '0;
            count_reg        <= '0;
            flight_reg       <= '0;
            inflight_reg     <= '0;
            prev_ack_reg     <= '0;
            gap_reg          <= 1'b0;
            err_reg          <= ERR_NONE;
            fill_reg         <= '0;
            walk_off_reg     <= '0;
            walk_end_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                err_reg <= ERR_NONE;
            end
            // Send: first number, checks and fill length.
            if (ctl.send_check)
            begin
                if (nothing_sent_reg)
                begin
                    oldest_reg       <= pn_reg;
                    nothing_sent_reg <= 1'b0;
                end
                if (send_back)
                begin
                    err_reg <= ERR_BACKWARD;
                end
                else if (send_full)
                begin
                    err_reg <= ERR_FULL;
                end
                fill_reg <= CNT_W'(send_dist) - count_reg;
            end
            // Empty entry for a skipped number.
            if (ctl.fill_step)
            begin
                inflight_reg[count_slot] <= 1'b0;
                count_reg                <= count_reg + CNT_W'(1);
                fill_reg                 <= fill_reg - CNT_W'(1);
            end
            // The sent packet itself.
            if (ctl.send_write)
            begin
                inflight_reg[count_slot] <= fl_reg;
                count_reg                <= count_reg + CNT_W'(1);
                if (fl_reg)
                begin
                    flight_reg <= flight_sum[FLIGHT_W] ? FLIGHT_MAX : flight_sum[FLIGHT_W-1:0];
                end
            end
            // Ack: stop-waiting, previous ack and walk range.
            if (ctl.ack_setup)
            begin
                if (order_err)
                begin
                    err_reg      <= ERR_ORDER;
                    walk_off_reg <= '0;
                    walk_end_reg <= '0;
                end
                else
                begin
                    gap_reg      <= (gap_reg && !first_reg) || gap_out;
                    prev_ack_reg <= pn_reg;
                    walk_off_reg <= gap_some ? lo_off : '0;
                    walk_end_reg <= gap_some ? hi_off : '0;
                end
            end
            if (ctl.walk_next)
            begin
                walk_off_reg <= walk_off_reg + CNT_W'(1);
                if (!inflight_reg[walk_slot])
                begin
                    gap_reg <= 1'b1;
                end
            end
            // Remove: take the packet out of flight.
            if (ctl.remove_clear)
            begin
                flight_reg             <= flight_reg - rm_sub;
                inflight_reg[rm_slot]  <= 1'b0;
            end
            // Prune: drop the head entry.
            if (ctl.prune_step)
            begin
                head_reg   <= ring_slot(head_reg, CNT_W'(1));
                count_reg  <= count_reg - CNT_W'(1);
                oldest_reg <= oldest_reg + PN_W'(1);
            end
            // Result register handshake.
            if (ctl.emit_lost || ctl.emit_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg    <= uapw_op_t'(in_op);
            pn_reg    <= in_data[PN_W-1:0];
            len_reg   <= in_data[PN_W +: LEN_W];
            fl_reg    <= in_data[PN_W + LEN_W];
            first_reg <= in_data[PN_W + LEN_W + 1];
        end
        if (ctl.emit_lost)
        begin
            out_data_reg <= OUT_DATA_W'({ERR_NONE, flight_reg, 1'b0, mem_rdata, lost_num});
            out_kind_reg <= KIND_LOST;
            out_last_reg <= 1'b0;
        end
        else if (ctl.emit_done)
        begin
            out_data_reg <= OUT_DATA_W'({err_reg, flight_reg, gap_reg, {LEN_W{1'b0}},
                                         {PN_W{1'b0}}});
            out_kind_reg <= KIND_DONE;
            out_last_reg <= 1'b1;
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.new_op     = uapw_op_t'(in_op);
        stat.err_set    = (err_reg != ERR_NONE);
        stat.fill_left  = (fill_reg != '0);
        stat.walk_more  = (walk_off_reg < walk_end_reg);
        stat.slot_busy  = inflight_reg[walk_slot];
        stat.rm_hit     = rm_in_win && inflight_reg[rm_slot];
        stat.prune_more = (count_reg != '0) && !inflight_reg[head_reg];
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/unacked_packet_window.sv
// Top level of the unacked packet window.
`default_nettype none

// Sender-side window of unacknowledged packets over 32 ring entries. One request
// is taken at a time; s_tready is high only while the block is idle, and the
// completion result (m_tuser high, m_tlast high) closes each request after any
// lost-packet reports. A send takes one step per skipped packet number; an ack
// one per gap number inside the window plus one more per lost report; a prune
// one per dropped entry. These steps come from a single walker that steps one
// ring entry a cycle, holding while a lost report waits for the output, and a
// byte RAM with one registered read port. The result register lets the next
// request enter while the last completion still waits to be taken.
module unacked_packet_window (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Bits from low: pkt_num[31:0], length[47:32], count_in_flight[48],
    // first_of_batch[49], zero fill.
    input  wire logic [uapw_pkg::IN_DATA_W-1:0]     s_tdata,
    // Bits from low: cmd[1:0].
    input  wire logic [1:0]                         s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // Bits from low: lost_number[31:0], lost_bytes[47:32], stop_waiting[48],
    // flight_bytes[70:49], error[72:71], zero fill.
    output logic [uapw_pkg::OUT_DATA_W-1:0]         m_tdata,
    // Bits from low: kind[0].
    output logic                                    m_tuser,
    output logic                                    m_tlast
);
    import uapw_pkg::*;

    uapw_ctl_t  ctl;
    uapw_stat_t stat;
    logic       in_ready;

    // The end-of-batch mark carries no meaning for the window.
    logic       batch_end_unused;
    assign batch_end_unused = s_tlast;

    uapw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid && !batch_end_unused || s_tvalid),
        .stat    (stat),
        .in_ready(in_ready),
        .ctl     (ctl)
    );

    uapw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .stat     (stat),
        .in_op    (s_tuser),
        .in_data  (s_tdata),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_kind (m_tuser),
        .out_last (m_tlast)
    );

    assign s_tready = in_ready;

endmodule

`default_nettype wire

// File: rtl/core/uapw_checker.sv
// Port-level checker of the unacked packet window and its bind.
`default_nettype none

`include "assert_macros.svh"

module uapw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [55:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // Only a completion closes a request.
    `ASSERT_CLKD(a_last_is_done, clk, rst_n, m_tvalid |-> (m_tuser == m_tlast))
    // Lost reports carry no stop-waiting and no error.
    `ASSERT_CLKD(a_lost_clean, clk, rst_n, (m_tvalid && !m_tuser) |-> (!m_tdata[48] && m_tdata[72:71] == 2'd0))
    // Lost reports only appear while a request is still at work.
    `ASSERT_CLKD(a_lost_busy, clk, rst_n, (m_tvalid && !m_tuser) |-> !s_tready)
    // A taken request closes the input until it completes.
    `ASSERT_CLKD(a_one_at_a_time, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)
    // A stalled result holds.
    `ASSERT_CLKD(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind unacked_packet_window uapw_checker u_uapw_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the unacked packet window.
`timescale 1ns / 100ps

module tb_top;
    import uapw_pkg::*;

    // One request as the sender sees it.
    typedef struct {
        uapw_op_t    op;
        logic [31:0] pn;
        logic [15:0] len;
        logic        in_flight;
        logic        first;
        logic        last_ack;
    } request_t;

    // One result as the block should deliver it.
    typedef struct packed {
        logic        kind;
        logic [31:0] lost_pn;
        logic [15:0] lost_len;
        logic        stop_wait;
        logic [21:0] flight;
        uapw_err_t   err;
        logic        last;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = 2'd0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    request_t       pending_reqs[$];
    request_t       on_bus;
    window_result_t expected_results[$];

    // Predictor state of the window.
    logic [31:0] w_oldest;
    logic        w_empty;
    int          w_head;
    int          w_count;
    logic [21:0] w_flight;
    logic        w_live[WINDOW_DEPTH];
    logic [15:0] w_bytes[WINDOW_DEPTH];
    logic [31:0] w_prev_ack;
    logic        w_gap;

    int  accepted_cnt = 0;
    int  lost_seen = 0;
    int  done_seen = 0;
    int  err_seen[4];
    int  mismatch_cnt = 0;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;

    unacked_packet_window u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int slot_at(int off);
        return (w_head + off) % WINDOW_DEPTH;
    endfunction

    function automatic void push_result(logic kind, logic [31:0] pn, logic [15:0] len,
                                        logic sw, uapw_err_t err, logic last);
        window_result_t r;
        r.kind = kind;
        r.lost_pn = pn;
        r.lost_len = len;
        r.stop_wait = sw;
        r.flight = w_flight;
        r.err = err;
        r.last = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Walk the gap [lo, hi): losses for in-flight entries, stop-waiting otherwise.
    function automatic void walk_gap(longint unsigned lo, longint unsigned hi);
        longint unsigned wlo;
        longint unsigned whi;
        longint unsigned a;
        longint unsigned b;
        int s;
        wlo = w_oldest;
        whi = wlo + w_count;
        if (lo >= hi)
        begin
            return;
        end
        if (w_empty || lo < wlo || hi > whi)
        begin
            w_gap = 1'b1;
        end
        a = (lo > wlo) ? lo : wlo;
        b = (hi < whi) ? hi : whi;
        for (longint unsigned i = a; i < b; i++)
        begin
            s = slot_at(int'(i - wlo));
            if (w_live[s])
            begin
                push_result(KIND_LOST, i[31:0], w_bytes[s], 1'b0, ERR_NONE, 1'b0);
            end
            else
            begin
                w_gap = 1'b1;
            end
        end
    endfunction

    // Apply one accepted request to the window and queue what it yields.
    function automatic void predict_window(request_t q);
        uapw_err_t err;
        longint unsigned nxt;
        longint unsigned sum;
        int s;
        err = ERR_NONE;
        case (q.op)
            OP_SEND:
            begin
                if (w_empty)
                begin
                    w_oldest = q.pn;
                    w_empty = 1'b0;
                end
                nxt = longint'(w_oldest) + w_count;
                if (longint'(q.pn) < nxt)
                begin
                    err = ERR_BACKWARD;
                end
                else if (longint'(q.pn) - w_oldest + 1 > WINDOW_DEPTH)
                begin
                    err = ERR_FULL;
                end
                else
                begin
                    while (longint'(w_oldest) + w_count < longint'(q.pn))
                    begin
                        s = slot_at(w_count);
                        w_live[s] = 1'b0;
                        w_bytes[s] = '0;
                        w_count++;
                    end
                    s = slot_at(w_count);
                    w_bytes[s] = q.len;
                    w_live[s] = q.in_flight;
                    w_count++;
                    if (q.in_flight)
                    begin
                        sum = longint'(w_flight) + q.len;
                        w_flight = (sum > FLIGHT_MAX) ? FLIGHT_MAX : sum[21:0];
                    end
                end
            end
            OP_ACK:
            begin
                if (q.first)
                begin
                    w_gap = 1'b0;
                    walk_gap(w_oldest, q.pn);
                    w_prev_ack = q.pn;
                end
                else if (q.pn <= w_prev_ack)
                begin
                    err = ERR_ORDER;
                end
                else
                begin
                    walk_gap(longint'(w_prev_ack) + 1, q.pn);
                    w_prev_ack = q.pn;
                end
            end
            OP_REMOVE:
            begin
                if (!w_empty && q.pn >= w_oldest &&
                    longint'(q.pn) < longint'(w_oldest) + w_count)
                begin
                    s = slot_at(int'(q.pn - w_oldest));
                    if (w_live[s])
                    begin
                        w_flight = (w_bytes[s] > w_flight) ? '0 : w_flight - w_bytes[s];
                        w_live[s] = 1'b0;
                    end
                end
            end
            default:
            begin
                while (w_count > 0 && !w_live[w_head])
                begin
                    w_head = (w_head + 1) % WINDOW_DEPTH;
                    w_count--;
                    w_oldest = w_oldest + 32'd1;
                end
            end
        endcase
        push_result(KIND_DONE, '0, '0, w_gap, err, 1'b1);
    endfunction

    // Sender: bursts of requests separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic loaded;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            loaded = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_window(on_bus);
                accepted_cnt++;
                loaded = 1'b0;
            end
            if (!loaded)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() > 0)
                begin
                    on_bus = pending_reqs[0];
                    pending_reqs.delete(0);
                    loaded = 1'b1;
                    s_tdata <= {6'd0, on_bus.first, on_bus.in_flight, on_bus.len, on_bus.pn};
                    s_tuser <= on_bus.op;
                    s_tlast <= on_bus.last_ack;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_tvalid <= loaded;
        end
    end

    // Receiver: changing stall pattern plus one long hold-off.
    int rx_cycle = 0;
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        int mode;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            mode = (rx_cycle / 97) % 3;
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (mode == 0)
            begin
                m_tready <= 1'b1;
            end
            else if (mode == 1)
            begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            else
            begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Checker: each result against the oldest expectation.
    always @(posedge clk)
    begin
        window_result_t got;
        window_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.lost_pn = m_tdata[31:0];
            got.lost_len = m_tdata[47:32];
            got.stop_wait = m_tdata[48];
            got.flight = m_tdata[70:49];
            got.err = uapw_err_t'(m_tdata[72:71]);
            got.last = m_tlast;
            if (expected_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("unexpected result %p", got);
                end
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.kind != want.kind || got.lost_pn != want.lost_pn ||
                    got.lost_len != want.lost_len || got.stop_wait != want.stop_wait ||
                    got.flight != want.flight || got.err != want.err ||
                    got.last != want.last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch: expected %p, got %p", want, got);
                    end
                end
                if (got.kind == KIND_LOST)
                begin
                    lost_seen++;
                end
                else
                begin
                    done_seen++;
                    err_seen[got.err]++;
                end
            end
        end
    end

    task automatic add_req(uapw_op_t op, logic [31:0] pn, logic [15:0] len = 16'd0,
                           logic fl = 1'b0, logic first = 1'b0, logic lastb = 1'b0);
        request_t q;
        q.op = op;
        q.pn = pn;
        q.len = len;
        q.in_flight = fl;
        q.first = first;
        q.last_ack = lastb;
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    task automatic wait_sent();
        while (pending_reqs.size() > 0 || s_tvalid)
        begin
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        wait_sent();
        while (expected_results.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    // Directed corner cases, then random traffic in chunks, partly with random fields.
    initial
    begin
        int queued;
        int pick;
        int n;
        logic [31:0] pn;
        w_oldest = '0;
        w_empty = 1'b1;
        w_head = 0;
        w_count = 0;
        w_flight = '0;
        w_prev_ack = '0;
        w_gap = 1'b0;
        foreach (w_live[i])
        begin
            w_live[i] = 1'b0;
            w_bytes[i] = '0;
        end
        foreach (err_seen[i])
        begin
            err_seen[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Before any send, then a window that wraps past the top number.
        add_req(OP_ACK, 32'd5, 16'd0, 1'b0, 1'b1, 1'b0);
        add_req(OP_ACK, 32'd3);
        add_req(OP_REMOVE, 32'd0);
        add_req(OP_PRUNE, 32'd0);
        add_req(OP_SEND, 32'hFFFF_FFF8, 16'hFFFF, 1'b1);
        add_req(OP_SEND, 32'hFFFF_FFFA, 16'h0000, 1'b1);
        add_req(OP_SEND, 32'hFFFF_FFF9, 16'd10, 1'b1);
        add_req(OP_SEND, 32'h0000_0018, 16'd10, 1'b1);
        add_req(OP_SEND, 32'hFFFF_FFFD, 16'd1234, 1'b0);
        add_req(OP_SEND, 32'hFFFF_FFFF, 16'h8000, 1'b1);
        add_req(OP_ACK, 32'hFFFF_FFFA, 16'd0, 1'b0, 1'b1, 1'b0);
        add_req(OP_ACK, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0, 1'b1);
        add_req(OP_ACK, 32'd5, 16'd0, 1'b0, 1'b1, 1'b1);
        add_req(OP_REMOVE, 32'hFFFF_FFF8);
        add_req(OP_REMOVE, 32'hFFFF_FFFA);
        add_req(OP_REMOVE, 32'hFFFF_FFFF);
        add_req(OP_REMOVE, 32'hFFFF_FFF8);
        add_req(OP_PRUNE, 32'd0);
        add_req(OP_SEND, 32'd0, 16'd7, 1'b1);
        add_req(OP_SEND, 32'd40, 16'd7, 1'b1);
        add_req(OP_SEND, 32'd31, 16'd9, 1'b1);
        add_req(OP_ACK, 32'd200, 16'd0, 1'b0, 1'b1, 1'b1);
        add_req(OP_REMOVE, 32'd0);
        add_req(OP_REMOVE, 32'd31);
        add_req(OP_PRUNE, 32'd0);
        queued = 25;
        // Sender holds back until every result is in.
        wait_drained();

        while (queued < 330)
        begin
            wait_sent();
            pick = $urandom_range(0, 99);
            if (queued > 120 && !hold_go)
            begin
                // Receiver stalls while a long run of sends keeps coming.
                hold_go = 1'b1;
                pick = 0;
            end
            if (pick < 30)
            begin
                n = $urandom_range(2, 10);
                pn = w_empty ? $urandom_range(0, 100) : w_oldest + w_count;
                repeat (n)
                begin
                    pn = pn + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                    add_req(OP_SEND, pn, 16'($urandom_range(0, 16'hFFFF)),
                            $urandom_range(0, 4) != 0);
                    pn = pn + 1;
                end
            end
            else if (pick < 55)
            begin
                n = $urandom_range(1, 6);
                pn = w_oldest + $urandom_range(0, 4) - 1;
                for (int k = 0; k < n; k++)
                begin
                    add_req(OP_ACK, pn, 16'($urandom_range(0, 16'hFFFF)),
                            1'($urandom_range(0, 1)),
                            (k == 0) && ($urandom_range(0, 9) != 0), k == n - 1);
                    pn = pn + $urandom_range(1, 4);
                end
            end
            else if (pick < 75)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    add_req(OP_REMOVE, w_oldest + $urandom_range(0, 33));
                end
                add_req(OP_PRUNE, $urandom());
                n = n + 1;
            end
            else if (pick < 85)
            begin
                n = 1;
                add_req(OP_PRUNE, $urandom(), 16'($urandom_range(0, 16'hFFFF)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    add_req(uapw_op_t'($urandom_range(0, 3)), $urandom(),
                            16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            queued += n;
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Covered %0d requests: %0d loss reports, %0d completions.",
                 accepted_cnt, lost_seen, done_seen);
        $display("Completions by error code: ok %0d, backward %0d, full %0d, order %0d.",
                 err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop for a hung run.
    initial
    begin
        #5000000;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
